FILE: sv/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// property must hold at every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, expr, msg)

`endif

`endif

FILE: sv/hrl_pkg.sv
package hrl_pkg;

   // hex digits in the load address field of a record
   localparam int ADDR_DIGITS = 4;
   localparam int DIGIT_W = $clog2(ADDR_DIGITS + 1);

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] CHAR_COLON   = 8'h3A;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_F = 8'h46;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_F = 8'h66;

   typedef enum logic [1:0] {
      KIND_WRITE = 2'd0,
      KIND_DONE  = 2'd1,
      KIND_ERROR = 2'd2
   } kind_type;

   typedef enum logic [5:0] {
      PH_COLON = 6'b000001,
      PH_COUNT = 6'b000010,
      PH_ADDR  = 6'b000100,
      PH_TYPE  = 6'b001000,
      PH_DATA  = 6'b010000,
      PH_CHECK = 6'b100000
   } phase_type;

   // one character after classification
   typedef struct packed {
      logic       is_colon;
      logic       is_hex;
      logic [3:0] nibble;
   } char_class_type;

endpackage

FILE: sv/hrl_queue.sv
`include "assert_macros.svh"

module hrl_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  hrl_pkg::char_class_type push_item,
   output logic                    full,
   input  logic                    pop,
   output logic                    head_valid,
   output hrl_pkg::char_class_type head_item
);

   hrl_pkg::char_class_type             slot_ff [hrl_pkg::QUEUE_DEPTH];
   logic [hrl_pkg::QPTR_W-1:0]          wr_ptr_ff, wr_ptr_in;
   logic [hrl_pkg::QPTR_W-1:0]          rd_ptr_ff, rd_ptr_in;
   logic [hrl_pkg::QCNT_W-1:0]          count_ff, count_in;
   logic                                do_pop;

   localparam logic [hrl_pkg::QPTR_W-1:0] LAST_SLOT = hrl_pkg::QPTR_W'(hrl_pkg::QUEUE_DEPTH - 1);
   localparam logic [hrl_pkg::QCNT_W-1:0] FULL_COUNT = hrl_pkg::QCNT_W'(hrl_pkg::QUEUE_DEPTH);

   assign full       = (count_ff == FULL_COUNT);
   assign head_valid = (count_ff != '0);
   assign head_item  = slot_ff[rd_ptr_ff];
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   `ASSERT_NEVER(a_no_overflow, clock, reset, push && full, "push into a full queue")
   `ASSERT_PROP(a_count_bound, clock, reset, count_ff <= FULL_COUNT, "queue count out of range")
   `ASSERT_PROP(a_pop_drains, clock, reset,
      (do_pop && !push && count_ff == 1) |=> !head_valid, "queue not empty after last pop")

endmodule

FILE: sv/hrl_front.sv
module hrl_front (
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [7:0]              req_tdata,
   input  logic                    queue_full,
   output logic                    push,
   output hrl_pkg::char_class_type push_item
);

   logic is_dec, is_upper, is_lower;

   assign is_dec   = (req_tdata >= hrl_pkg::CHAR_ZERO) && (req_tdata <= hrl_pkg::CHAR_NINE);
   assign is_upper = (req_tdata >= hrl_pkg::CHAR_UPPER_A) && (req_tdata <= hrl_pkg::CHAR_UPPER_F);
   assign is_lower = (req_tdata >= hrl_pkg::CHAR_LOWER_A) && (req_tdata <= hrl_pkg::CHAR_LOWER_F);

   assign req_tready = !queue_full;
   assign push       = req_tvalid && !queue_full;

   always_comb begin
      push_item.is_colon = (req_tdata == hrl_pkg::CHAR_COLON);
      push_item.is_hex   = is_dec || is_upper || is_lower;
      if (is_upper) begin
         push_item.nibble = 4'(req_tdata - hrl_pkg::CHAR_UPPER_A + 8'd10);
      end else if (is_lower) begin
         push_item.nibble = 4'(req_tdata - hrl_pkg::CHAR_LOWER_A + 8'd10);
      end else begin
         push_item.nibble = 4'(req_tdata - hrl_pkg::CHAR_ZERO);
      end
   end

endmodule

FILE: sv/hrl_back.sv
`include "assert_macros.svh"

module hrl_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    item_valid,
   input  hrl_pkg::char_class_type item,
   output logic                    item_pop,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [23:0]             rsp_tdata,
   output logic [1:0]              rsp_tuser
);

   localparam logic [hrl_pkg::DIGIT_W-1:0] TWO_DIGITS  = hrl_pkg::DIGIT_W'(2);
   localparam logic [hrl_pkg::DIGIT_W-1:0] ADDR_COUNT  = hrl_pkg::DIGIT_W'(hrl_pkg::ADDR_DIGITS);
   localparam logic [hrl_pkg::DIGIT_W-1:0] ONE_DIGIT   = hrl_pkg::DIGIT_W'(1);

   hrl_pkg::phase_type             phase_ff, phase_in;
   logic [hrl_pkg::DIGIT_W-1:0]    digits_ff, digits_in;
   logic [15:0]                    acc_ff, acc_in;
   logic [15:0]                    acc_shift;
   logic [7:0]                     bytes_ff, bytes_in;
   logic [7:0]                     bytes_dec;
   logic [15:0]                    wptr_ff, wptr_in;
   logic [7:0]                     rkind_ff, rkind_in;
   logic                           halted_ff, halted_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   hrl_pkg::kind_type              rsp_kind_ff, out_kind;
   logic [15:0]                    rsp_addr_ff, out_addr;
   logic [7:0]                     rsp_byte_ff, out_byte;
   logic                           out_load;

   assign item_pop   = item_valid && (!rsp_valid_ff || rsp_tready);
   assign acc_shift  = {acc_ff[11:0], item.nibble};
   assign bytes_dec  = bytes_ff - 8'd1;

   always_comb begin
      phase_in  = phase_ff;
      digits_in = digits_ff;
      acc_in    = acc_ff;
      bytes_in  = bytes_ff;
      wptr_in   = wptr_ff;
      rkind_in  = rkind_ff;
      halted_in = halted_ff;
      out_load  = 1'b0;
      out_kind  = hrl_pkg::KIND_WRITE;
      out_addr  = '0;
      out_byte  = '0;
      if (item_pop && !halted_ff) begin
         unique case (phase_ff) inside
            hrl_pkg::PH_COLON: begin
               if (!item.is_colon) begin
                  out_load  = 1'b1;
                  out_kind  = hrl_pkg::KIND_ERROR;
                  halted_in = 1'b1;
               end else begin
                  phase_in  = hrl_pkg::PH_COUNT;
                  digits_in = TWO_DIGITS;
                  acc_in    = '0;
               end
            end
            hrl_pkg::PH_CHECK: begin
               if (digits_ff > ONE_DIGIT) begin
                  digits_in = digits_ff - 1'b1;
               end else if (rkind_ff != '0) begin
                  out_load  = 1'b1;
                  out_kind  = hrl_pkg::KIND_DONE;
                  halted_in = 1'b1;
               end else begin
                  phase_in  = hrl_pkg::PH_COLON;
                  digits_in = '0;
                  acc_in    = '0;
               end
            end
            hrl_pkg::PH_COUNT, hrl_pkg::PH_ADDR, hrl_pkg::PH_TYPE, hrl_pkg::PH_DATA: begin
               if (!item.is_hex) begin
                  out_load  = 1'b1;
                  out_kind  = hrl_pkg::KIND_ERROR;
                  halted_in = 1'b1;
               end else if (digits_ff > ONE_DIGIT) begin
                  digits_in = digits_ff - 1'b1;
                  acc_in    = acc_shift;
               end else begin
                  // field complete
                  acc_in = '0;
                  case (phase_ff)
                     hrl_pkg::PH_COUNT: begin
                        bytes_in  = acc_shift[7:0];
                        phase_in  = hrl_pkg::PH_ADDR;
                        digits_in = ADDR_COUNT;
                     end
                     hrl_pkg::PH_ADDR: begin
                        wptr_in   = acc_shift;
                        phase_in  = hrl_pkg::PH_TYPE;
                        digits_in = TWO_DIGITS;
                     end
                     hrl_pkg::PH_TYPE: begin
                        rkind_in  = acc_shift[7:0];
                        phase_in  = (bytes_ff == '0) ? hrl_pkg::PH_CHECK : hrl_pkg::PH_DATA;
                        digits_in = TWO_DIGITS;
                     end
                     default: begin
                        out_load  = 1'b1;
                        out_kind  = hrl_pkg::KIND_WRITE;
                        out_addr  = wptr_ff;
                        out_byte  = acc_shift[7:0];
                        wptr_in   = wptr_ff + 16'd1;
                        bytes_in  = bytes_dec;
                        phase_in  = (bytes_dec == '0) ? hrl_pkg::PH_CHECK : hrl_pkg::PH_DATA;
                        digits_in = TWO_DIGITS;
                     end
                  endcase
               end
            end
            default: begin
               // corrupted phase code
               out_load  = 1'b1;
               out_kind  = hrl_pkg::KIND_ERROR;
               halted_in = 1'b1;
            end
         endcase
      end
   end

   always_comb begin
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= hrl_pkg::PH_COLON;
         digits_ff    <= '0;
         acc_ff       <= '0;
         bytes_ff     <= '0;
         wptr_ff      <= '0;
         rkind_ff     <= '0;
         halted_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         digits_ff    <= digits_in;
         acc_ff       <= acc_in;
         bytes_ff     <= bytes_in;
         wptr_ff      <= wptr_in;
         rkind_ff     <= rkind_in;
         halted_ff    <= halted_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_kind_ff <= out_kind;
         rsp_addr_ff <= out_addr;
         rsp_byte_ff <= out_byte;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_byte_ff, rsp_addr_ff};
   assign rsp_tuser  = rsp_kind_ff;

   `ASSERT_PROP(a_halt_sticks, clock, reset, halted_ff |=> halted_ff, "halt cleared without reset")
   `ASSERT_PROP(a_stop_halts, clock, reset,
      (out_load && out_kind != hrl_pkg::KIND_WRITE) |=> halted_ff, "stop result without halt")
   `ASSERT_NEVER(a_no_result_halted, clock, reset, out_load && halted_ff,
      "result produced while halted")

endmodule

FILE: sv/hex_record_loader_parser.sv
// hex record loader parser
// req channel: one ascii character of the image text per transaction
//    (req_tdata[7:0]); records are ':' count address type data checksum,
//    back to back with no line breaks, hex digits in either case.
// rsp channel: at most one transaction per character. rsp_tuser is the kind
//    (0 write byte, 1 load finished, 2 stopped on a bad character);
//    rsp_tdata carries the load address and data byte for kind 0, else zero.
// a front stage classifies each character and pushes it into a four-entry
//    queue; the back stage parses from the queue into a one-entry output
//    register.
// throughput: one character per cycle when rsp_tready stays high.
// path: an accepted character is written into the queue; the back stage
//    parses it from the queue head and loads any result into the output
//    register, from which its rsp transaction completes.
// stall: while a result waits in the output register with rsp_tready low
//    the back stage stops; the queue keeps taking characters until it holds
//    four, then req_tready drops.
// after a finished or error result the parser ignores all further
//    characters (still accepting them) until reset.
// reset: synchronous, clears the queue, the parser state and rsp_tvalid.
module hex_record_loader_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // text_char[7:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // load_address[15:0], byte_value[23:16]
   output logic [1:0]  rsp_tuser    // kind[1:0]
);

   hrl_pkg::char_class_type push_item, head_item;
   logic                    push, queue_full, head_valid, head_pop;

   hrl_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .queue_full (queue_full),
      .push       (push),
      .push_item  (push_item)
   );

   hrl_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .full       (queue_full),
      .pop        (head_pop),
      .head_valid (head_valid),
      .head_item  (head_item)
   );

   hrl_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (head_valid),
      .item       (head_item),
      .item_pop   (head_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
